// ----- hdl/lru_cache_hit_tracker_defines.svh -----
// ---------------------------------------------------------------------------
// lru cache hit tracker assertion macros
// shared property wrappers for the port-level checker
// ---------------------------------------------------------------------------
`ifndef LRU_CACHE_HIT_TRACKER_DEFINES_SVH
`define LRU_CACHE_HIT_TRACKER_DEFINES_SVH

// implication checked on the same edge, off while reset is asserted
`define LRUT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru tracker port check failed");

// implication checked at the following edge, off while reset is asserted
`define LRUT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru tracker port check failed");

// implication checked at the following edge, live through reset
`define LRUT_ASSERT_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lru tracker reset check failed");

`endif

// ----- hdl/lrut_pkg.sv -----
// ---------------------------------------------------------------------------
// lrut_pkg
// types and constants shared by the lru tracker cells and top level
// ---------------------------------------------------------------------------
`default_nettype none

package lrut_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // broadcast from the control to every cell of the stack
  typedef struct packed {
    logic cmp_en;  // latch key match against the incoming beat
    logic upd_en;  // apply the stack shift
    logic hit;     // current access hit somewhere in the stack
    logic evict;   // miss that drops the lru entry
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lrut_cell.sv -----
// ---------------------------------------------------------------------------
// lrut_cell
// one slot of the lru stack: key, valid, match flag, shift from neighbor
// ---------------------------------------------------------------------------
`default_nettype none

module lrut_cell
  import lrut_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [KEY_W-1:0] cmp_key,
  input  wire logic [KEY_W-1:0] prev_key,
  input  wire logic             prev_valid,
  input  wire logic             sfx_in,
  output logic                  sfx_out,
  output logic [KEY_W-1:0]      key_out,
  output logic                  valid_out
);

  logic [KEY_W-1:0] key_r;
  logic             valid_r;
  logic             match_r;
  logic             shift;

  // hit at this slot or further toward the lru end
  assign sfx_out = match_r | sfx_in;

  // hit: slots up to the hit shift; miss: fill one more slot or drop the last
  always_comb begin
    shift = 1'b0;
    if (ctrl.upd_en) begin
      if (ctrl.hit) begin
        shift = sfx_out;
      end else if (ctrl.evict) begin
        shift = valid_r;
      end else begin
        shift = prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
      if (shift) begin
        valid_r <= prev_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r <= prev_key;
    end
  end

  assign key_out   = key_r;
  assign valid_out = valid_r;

endmodule

`default_nettype wire

// ----- hdl/lru_cache_hit_tracker.sv -----
// timing: an accepted beat latches its key and match flags; the update state then shifts
// the stack and registers the result, waiting while out_stall holds a result back
// flow: in_stall holds through the update state, so one access is in flight at a time
// reset: synchronous on rst_n; the stack empties, capacity returns to 16, no results pend
// ---------------------------------------------------------------------------
// lru_cache_hit_tracker
// fully associative lru hit tracker built as a shifting stack of cells,
// slot 0 most recently used
// ---------------------------------------------------------------------------
`default_nettype none

module lru_cache_hit_tracker
  import lrut_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [KEY_W-1:0] in_access_key,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_hit,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CAP_W-1:0]        cfg_cache_capacity
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  state_t             state_r, state_nxt;
  logic [KEY_W-1:0]   key_r;
  logic [CAP_W-1:0]   cap_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r;
  logic               accept;
  logic               upd_fire;
  logic               out_free;
  logic               any_hit;
  logic               evict;
  logic [EW-1:0]      cap_ext;
  logic [EW-1:0]      eff_cap;
  cell_ctrl_t         ctrl;

  logic [KEY_W-1:0]     cell_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_valid;
  logic [MAX_ENTRIES:0]   hit_sfx;

  assign cfg_ready = 1'b1;
  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign any_hit   = hit_sfx[0];

  // capacity zero acts as one, above the stack depth acts as the depth
  assign cap_ext = EW'(cap_r);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end
  end

  assign evict = !any_hit && (count_r != '0) && (EW'(count_r) >= eff_cap);

  always_comb begin
    state_nxt     = state_r;
    upd_fire      = 1'b0;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          upd_fire      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (!any_hit && !evict) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ctrl.cmp_en = accept;
  assign ctrl.upd_en = upd_fire;
  assign ctrl.hit    = any_hit;
  assign ctrl.evict  = evict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_cache_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= $unsigned(in_access_key);
    end
    if (upd_fire) begin
      out_hit_r <= any_hit;
    end
  end

  assign hit_sfx[MAX_ENTRIES] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic             prev_valid;

    // slot 0 takes the accessed key, every other slot its neighbor's
    if (i == 0) begin : g_head
      assign prev_key   = key_r;
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_key   = cell_key[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    lrut_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .cmp_key    ($unsigned(in_access_key)),
      .prev_key   (prev_key),
      .prev_valid (prev_valid),
      .sfx_in     (hit_sfx[i+1]),
      .sfx_out    (hit_sfx[i]),
      .key_out    (cell_key[i]),
      .valid_out  (cell_valid[i])
    );
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

`default_nettype wire

// ----- hdl/lrut_checker.sv -----
// ---------------------------------------------------------------------------
// lrut_checker
// port-level checks on the lru tracker, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "lru_cache_hit_tracker_defines.svh"

module lrut_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_hit
);

  // a held result keeps its value
  `LRUT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit))

  // one access in flight: the beat after an accept is stalled
  `LRUT_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

  // a fresh result rises from an accepted beat via the update state and the result register
  `LRUT_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

  // reset leaves no result pending
  `LRUT_ASSERT_RAW(a_reset_empty, !rst_n, !out_valid && in_stall == !rst_n)

endmodule

bind lru_cache_hit_tracker lrut_checker u_lrut_checker (.*);

`default_nettype wire

// ----- bench/lru_cache_hit_tracker_tb.sv -----
// ---------------------------------------------------------------------------
// lru_cache_hit_tracker_tb
// self-checking bench: a short table of directed accesses and capacity writes,
// then random key streams over a set of capacities, each result compared
// against an in-bench lru model, with random idle and stall bursts on both sides
// ---------------------------------------------------------------------------
`default_nettype none

module lru_cache_hit_tracker_tb;
  import lrut_pkg::*;

  localparam int SLOTS      = 16;
  localparam int CYCLE_CAP  = 500000;
  localparam int RAND_ITEMS = 1700;
  localparam int N_DIR      = 22;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [KEY_W-1:0] in_access_key;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_hit;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_cache_capacity;

  lru_cache_hit_tracker #(.MAX_ENTRIES(SLOTS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_access_key      (in_access_key),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit            (out_hit),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_cache_capacity (cfg_cache_capacity)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // directed step: either a capacity write or an access, with an optional typed answer
  typedef struct packed {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    logic [KEY_W-1:0] key;
    bit               known;
    bit               want_hit;
  } dir_row_t;

  dir_row_t dir_rows [0:N_DIR-1] = '{
    '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 1'b0},  // empty after reset
    '{1'b0, 5'd0,  32'h0000_0000, 1'b1, 1'b1},
    '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'h7fff_ffff, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'hffff_ffff, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'h8000_0000, 1'b1, 1'b1},
    '{1'b0, 5'd0,  32'h0000_0001, 1'b1, 1'b0},  // one bit off a resident key
    '{1'b0, 5'd0,  32'hffff_fffe, 1'b1, 1'b0},
    '{1'b1, 5'd1,  32'h0,         1'b0, 1'b0},  // shrink below residents
    '{1'b0, 5'd0,  32'h7fff_ffff, 1'b1, 1'b1},  // still found among residents
    '{1'b0, 5'd0,  32'h1234_5678, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'h0000_0000, 1'b0, 1'b0},
    '{1'b1, 5'd0,  32'h0,         1'b0, 1'b0},  // zero acts as one
    '{1'b0, 5'd0,  32'h1234_5678, 1'b0, 1'b0},
    '{1'b0, 5'd0,  32'ha5a5_a5a5, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'ha5a5_a5a5, 1'b1, 1'b1},
    '{1'b1, 5'd31, 32'h0,         1'b0, 1'b0},  // above the slot count
    '{1'b0, 5'd0,  32'h5a5a_5a5a, 1'b1, 1'b0},
    '{1'b0, 5'd0,  32'h5a5a_5a5a, 1'b1, 1'b1},
    '{1'b1, 5'd16, 32'h0,         1'b0, 1'b0},
    '{1'b0, 5'd0,  32'h25a5_a5a5, 1'b1, 1'b0},  // top bit differs from a resident
    '{1'b0, 5'd0,  32'ha5a5_a5a5, 1'b0, 1'b0}
  };

  // model of the tag store
  logic [KEY_W-1:0] tag_key  [SLOTS];
  bit               tag_vld  [SLOTS];
  int               tag_rank [SLOTS];
  int               resident;
  logic [CAP_W-1:0] capacity;

  bit pending_hits [$];

  logic row_known;
  logic row_want;
  bit   calm;
  int   mismatches;
  int   accesses;
  int   hits_seen;
  int   cap_writes;
  int   cycles;

  function automatic bit lookup_and_update(input logic [KEY_W-1:0] key);
    int slot;
    int eff;
    int r;
    bit done;
    slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot < 0 && tag_vld[i] && tag_key[i] == key) slot = i;
    if (slot >= 0) begin
      r = tag_rank[slot];
      for (int i = 0; i < SLOTS; i++)
        if (tag_vld[i] && tag_rank[i] < r) tag_rank[i]++;
      tag_rank[slot] = 0;
      return 1'b1;
    end
    eff = (capacity == 0) ? 1 : ((capacity > SLOTS) ? SLOTS : int'(capacity));
    // evict the single oldest entry once the residents reach the limit
    if (resident > 0 && resident >= eff) begin
      done = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!done && tag_vld[i] && tag_rank[i] == resident - 1) begin
          tag_vld[i]  = 1'b0;
          tag_rank[i] = 0;
          resident--;
          done = 1'b1;
        end
      end
    end
    for (int i = 0; i < SLOTS; i++)
      if (tag_vld[i]) tag_rank[i]++;
    done = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!done && !tag_vld[i]) begin
        tag_vld[i]  = 1'b1;
        tag_key[i]  = key;
        tag_rank[i] = 0;
        resident++;
        done = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // result check first, then the beats accepted at this edge
  always @(posedge clk) begin
    bit want;
    bit model_hit;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_vld[i]  = 1'b0;
        tag_rank[i] = 0;
        tag_key[i]  = '0;
      end
      resident = 0;
      capacity = CAP_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] result beat with nothing pending, hit=%0b", cycles, out_hit);
        end else begin
          want = pending_hits.pop_front();
          if (out_hit !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0d] hit mismatch: expected %0b, got %0b", cycles, want, out_hit);
          end
          if (want) hits_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        model_hit = lookup_and_update(in_access_key);
        pending_hits.push_back(row_known ? row_want : model_hit);
        accesses++;
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_cache_capacity;
        cap_writes++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_hits.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // result side back-pressure in bursts
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 16);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_key(input logic [KEY_W-1:0] key, input bit known, input bit want);
    in_valid      <= 1'b1;
    in_access_key <= key;
    row_known     <= known;
    row_want      <= want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_cache_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'd31;
      4:       return 5'($urandom_range(17, 30));
      5:       return 5'($urandom_range(1, 4));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  initial begin
    logic [KEY_W-1:0] pool [0:23];
    logic [KEY_W-1:0] key;
    int pool_n;
    int run_len;
    int sent;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_access_key      <= '0;
    row_known          <= 1'b0;
    row_want           <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_cache_capacity <= '0;
    calm       = 1'b0;
    mismatches = 0;
    accesses   = 0;
    hits_seen  = 0;
    cap_writes = 0;
    cycles     = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_capacity(dir_rows[i].cap);
      end else begin
        send_key(dir_rows[i].key, dir_rows[i].known, dir_rows[i].want_hit);
        maybe_pause();
      end
    end

    // random phases: each one a fresh capacity and a small working set of keys
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (RAND_ITEMS - sent <= 200) begin
        calm    = 1'b1;
        run_len = RAND_ITEMS - sent;
      end else begin
        calm    = ($urandom_range(0, 5) == 0);
        run_len = $urandom_range(60, 200);
      end
      set_capacity(pick_capacity());
      pool_n = $urandom_range(2, 24);
      for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
      for (int n = 0; n < run_len; n++) begin
        case ($urandom_range(0, 9))
          0:       key = $urandom;
          1:       key = pool[$urandom_range(0, pool_n - 1)] ^ (32'h1 << $urandom_range(0, 31));
          default: key = pool[$urandom_range(0, pool_n - 1)];
        endcase
        send_key(key, 1'b0, 1'b0);
        maybe_pause();
      end
      sent += run_len;
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d accesses (%0d hits, %0d misses) over %0d capacity writes",
             accesses, hits_seen, accesses - hits_seen, cap_writes);
    $display("%0d mismatching results, %0d left pending", mismatches, pending_hits.size());
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
